// ===== rtl/rbsi_pkg.sv =====
package rbsi_pkg;

    localparam int unsigned AXES        = 3;
    localparam int unsigned DIVS        = 2 * AXES;
    localparam int unsigned NUM_W       = 49;
    localparam int unsigned DEN_W       = 32;
    localparam int unsigned QUO_W       = 32;
    // One overflow stage plus one stage per quotient bit.
    localparam int unsigned DIV_STAGES  = QUO_W + 1;
    // Side flags wait for the input stage and the divider.
    localparam int unsigned SIDE_DEPTH  = DIV_STAGES + 1;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } t_ray_in;

    typedef struct packed {
        logic        hit;
        logic [30:0] entry_distance;
    } t_ray_out;

    typedef struct packed {
        logic              vld;
        logic [AXES-1:0]   par;
        logic [AXES-1:0]   pmiss;
    } t_side;

    typedef struct packed {
        logic [QUO_W-1:0] q;
        logic             ovf;
        logic             neg;
    } t_quot;

endpackage

// ===== rtl/rbsi_if.sv =====
interface rbsi_in_if;
    import rbsi_pkg::*;
    logic    valid;
    logic    ready;
    t_ray_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbsi_out_if;
    import rbsi_pkg::*;
    logic     valid;
    logic     ready;
    t_ray_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rbsi_div.sv =====
module rbsi_div
    import rbsi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic             i_neg,
    output t_quot            o_quot
);

    // Unsigned restoring division, one quotient bit per stage.
    logic [DEN_W-1:0] r_rem [DIV_STAGES];
    logic [QUO_W-1:0] r_low [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic [QUO_W-1:0] r_q   [DIV_STAGES];
    logic             r_ovf [DIV_STAGES];
    logic             r_neg [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= {15'd0, i_num[NUM_W-1:QUO_W]} >= i_den;
            r_rem[0] <= {15'd0, i_num[NUM_W-1:QUO_W]};
            r_low[0] <= i_num[QUO_W-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
        logic [DEN_W:0] w_trial;
        logic           w_ge;
        assign w_trial = {r_rem[k-1], r_low[k-1][QUO_W-k]};
        assign w_ge    = w_trial >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? DEN_W'(w_trial - {1'b0, r_den[k-1]})
                                 : w_trial[DEN_W-1:0];
                r_q[k]   <= {r_q[k-1][QUO_W-2:0], w_ge};
                r_low[k] <= r_low[k-1];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign o_quot.q   = r_q[DIV_STAGES-1];
    assign o_quot.ovf = r_ovf[DIV_STAGES-1];
    assign o_quot.neg = r_neg[DIV_STAGES-1];

endmodule

// ===== rtl/rbsi_merge.sv =====
module rbsi_merge
    import rbsi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_side    i_side,
    input  t_quot    i_quot [DIVS],
    output logic     o_valid,
    output t_ray_out o_data
);

    logic signed [31:0] n_t [DIVS];
    logic signed [31:0] r_t [DIVS];
    t_side              r_side;
    logic               r_valid;
    t_ray_out           r_data;
    logic signed [31:0] w_lo;
    logic signed [31:0] w_hi;
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    t_ray_out           n_data;

    // Saturate each quotient to the signed Q16.16 range.
    always_comb begin
        for (int i = 0; i < DIVS; i++) begin
            if (i_quot[i].neg) begin
                if (i_quot[i].ovf || (i_quot[i].q[31] && (|i_quot[i].q[30:0])))
                    n_t[i] = Q_MIN;
                else
                    n_t[i] = -$signed(i_quot[i].q);
            end else begin
                if (i_quot[i].ovf || i_quot[i].q[31])
                    n_t[i] = Q_MAX;
                else
                    n_t[i] = $signed({1'b0, i_quot[i].q[30:0]});
            end
        end
    end

    // Order each pair and narrow the interval; parallel axes leave it alone.
    always_comb begin
        w_lo = '0;
        w_hi = Q_MAX;
        w_a  = '0;
        w_b  = '0;
        for (int a = 0; a < AXES; a++) begin
            w_a = (r_t[2*a] > r_t[2*a+1]) ? r_t[2*a+1] : r_t[2*a];
            w_b = (r_t[2*a] > r_t[2*a+1]) ? r_t[2*a] : r_t[2*a+1];
            if (!r_side.par[a]) begin
                if (w_a > w_lo) w_lo = w_a;
                if (w_b < w_hi) w_hi = w_b;
            end
        end
        n_data.hit            = !(|r_side.pmiss) && (w_lo <= w_hi);
        n_data.entry_distance = n_data.hit ? w_lo[30:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
            r_valid    <= 1'b0;
        end else if (i_en) begin
            r_side.vld <= i_side.vld;
            r_valid    <= r_side.vld;
        end
        if (i_en) begin
            r_t          <= n_t;
            r_side.par   <= i_side.par;
            r_side.pmiss <= i_side.pmiss;
            r_data       <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/ray_box_slab_intersect_unit.sv =====
// Ray against axis-aligned box test, slab method, fully pipelined.
//
// Channels: i_ray takes one word per test carrying the ray origin, the ray
// direction and the two box corners, all signed Q16.16. o_res returns one
// word per test with the hit flag and the entry distance (zero on a miss).
// Both use valid/ready; a word moves on a clock edge where both are high.
//
// Throughput is one test per cycle while o_res is not stalled. After
// acceptance a register takes the six numerators and divisor magnitudes,
// the six parallel restoring dividers follow (an overflow check and then
// one quotient bit per stage), a register takes the saturated distances,
// and ordering them and narrowing the interval fill the output register.
//
// The whole pipeline advances together whenever the output register is
// empty or being taken, so when the receiver stalls every stage holds its
// word and i_ray.ready drops; nothing is lost or repeated.
//
// Reset (i_rst_n low at a clock edge) clears all valid bits; data registers
// are left as they are. Words in flight at reset are dropped.
module ray_box_slab_intersect_unit
    import rbsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbsi_in_if.sink     i_ray,
    rbsi_out_if.source  o_res
);

    logic               w_adv;
    logic signed [31:0] w_o  [AXES];
    logic signed [31:0] w_d  [AXES];
    logic signed [31:0] w_mn [AXES];
    logic signed [31:0] w_mx [AXES];

    logic [NUM_W-1:0]   n_num [DIVS];
    logic [DEN_W-1:0]   n_den [DIVS];
    logic               n_neg [DIVS];
    logic [NUM_W-1:0]   r_num [DIVS];
    logic [DEN_W-1:0]   r_den [DIVS];
    logic               r_neg [DIVS];
    t_side              n_side;
    t_side              r_side [SIDE_DEPTH];
    t_quot              w_quot [DIVS];

    // The pipeline moves when the output register is free or being emptied.
    assign w_adv       = !o_res.valid || o_res.ready;
    assign i_ray.ready = w_adv;

    assign w_o[0]  = i_ray.data.origin_x;
    assign w_o[1]  = i_ray.data.origin_y;
    assign w_o[2]  = i_ray.data.origin_z;
    assign w_d[0]  = i_ray.data.dir_x;
    assign w_d[1]  = i_ray.data.dir_y;
    assign w_d[2]  = i_ray.data.dir_z;
    assign w_mn[0] = i_ray.data.box_min_x;
    assign w_mn[1] = i_ray.data.box_min_y;
    assign w_mn[2] = i_ray.data.box_min_z;
    assign w_mx[0] = i_ray.data.box_max_x;
    assign w_mx[1] = i_ray.data.box_max_y;
    assign w_mx[2] = i_ray.data.box_max_z;

    // Per axis, the bound minus the origin is exact at 33 bits. Its
    // magnitude scaled by one in Q16.16 is the dividend; the sign of the
    // quotient is kept aside and applied after the divide.
    always_comb begin
        logic signed [32:0] diff;
        logic [32:0]        mag;
        diff = '0;
        mag  = '0;
        n_side.vld = i_ray.valid && i_ray.ready;
        for (int a = 0; a < AXES; a++) begin
            n_side.par[a]   = (w_d[a] == '0);
            n_side.pmiss[a] = n_side.par[a] && ((w_o[a] < w_mn[a]) || (w_o[a] > w_mx[a]));
            for (int s = 0; s < 2; s++) begin
                diff = (s == 0) ? ({w_mn[a][31], w_mn[a]} - {w_o[a][31], w_o[a]})
                                : ({w_mx[a][31], w_mx[a]} - {w_o[a][31], w_o[a]});
                mag  = diff[32] ? 33'(-diff) : 33'(diff);
                n_num[2*a+s] = {mag, 16'd0};
                n_den[2*a+s] = w_d[a][31] ? 32'(-w_d[a]) : 32'(w_d[a]);
                n_neg[2*a+s] = diff[32] ^ w_d[a][31];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num <= n_num;
            r_den <= n_den;
            r_neg <= n_neg;
        end
    end

    // Flags of each test travel alongside it through the dividers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_DEPTH; k++) r_side[k].vld <= 1'b0;
        end else if (w_adv) begin
            r_side[0].vld <= n_side.vld;
            for (int k = 1; k < SIDE_DEPTH; k++) r_side[k].vld <= r_side[k-1].vld;
        end
        if (w_adv) begin
            r_side[0].par   <= n_side.par;
            r_side[0].pmiss <= n_side.pmiss;
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                r_side[k].par   <= r_side[k-1].par;
                r_side[k].pmiss <= r_side[k-1].pmiss;
            end
        end
    end

    for (genvar i = 0; i < DIVS; i++) begin : g_div
        rbsi_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_num  (r_num[i]),
            .i_den  (r_den[i]),
            .i_neg  (r_neg[i]),
            .o_quot (w_quot[i])
        );
    end

    rbsi_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_side  (r_side[SIDE_DEPTH-1]),
        .i_quot  (w_quot),
        .o_valid (o_res.valid),
        .o_data  (o_res.data)
    );

`ifndef SYNTH
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.hit |-> o_res.data.entry_distance == '0)
        else $error("miss reported with nonzero entry distance");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ray.ready == (!o_res.valid || o_res.ready))
        else $error("input ready disagrees with output stall");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.data))
        else $error("stalled result changed");
`endif

endmodule
